/* hdl/gfp_pkg.sv */
// gfp_pkg: shared types and constants of the gray field packer
package gfp_pkg;

  localparam int ValueW  = 20;
  localparam int WidthW  = 5;
  localparam int PackedW = 24;

  typedef enum logic [1:0] {
    CmdPack,
    CmdFlush,
    CmdBad
  } gfp_cmd_e;

  typedef struct packed {
    gfp_cmd_e            kind;
    logic [WidthW-1:0]   width;
    logic [ValueW-1:0]   coded;
  } gfp_cmd_t;

endpackage

/* hdl/gfp_if.sv */
// gfp_if: request and result channel interfaces of the gray field packer
interface gfp_in_if
  import gfp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [WidthW-1:0] field_width;
  logic [ValueW-1:0] field_value;

  modport source (output valid, output req_type, output field_width, output field_value,
                  input ready);
  modport sink (input valid, input req_type, input field_width, input field_value,
                output ready);
endinterface

interface gfp_out_if
  import gfp_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [PackedW-1:0] packed_word;
  logic               last_word;
  logic               bad_request;

  modport source (output valid, output packed_word, output last_word, output bad_request,
                  input ready);
  modport sink (input valid, input packed_word, input last_word, input bad_request,
                output ready);
endinterface

/* hdl/gfp_front.sv */
// gfp_front: request checking and gray coding into packer commands
module gfp_front
  import gfp_pkg::*;
#(
  parameter int WordBits = 24,
  parameter int MinField = 2,
  parameter int MaxField = 20
) (
  input  logic              req_type_i,
  input  logic [WidthW-1:0] field_width_i,
  input  logic [ValueW-1:0] field_value_i,
  output gfp_cmd_t          cmd_o
);

  localparam logic [6:0] MinW  = 7'(MinField);
  localparam logic [6:0] MaxW  = 7'(MaxField);
  localparam logic [6:0] WordW = 7'(WordBits);

  logic [6:0] width_ext;
  logic       bad;

  assign width_ext = {2'b00, field_width_i};
  assign bad = (width_ext < MinW) || (width_ext > MaxW) || (width_ext > WordW) ||
               ((field_value_i >> field_width_i) != '0);

  always_comb begin
    cmd_o.width = field_width_i;
    cmd_o.coded = field_value_i ^ (field_value_i >> 1);
    if (req_type_i) begin
      cmd_o.kind = CmdFlush;
    end else if (bad) begin
      cmd_o.kind = CmdBad;
    end else begin
      cmd_o.kind = CmdPack;
    end
  end

endmodule

/* hdl/gfp_fifo.sv */
// gfp_fifo: two-entry command queue between front and back
module gfp_fifo
  import gfp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  gfp_cmd_t data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output gfp_cmd_t data_o
);

  gfp_cmd_t   mem_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d  = wptr_q ^ do_push;
    rptr_d  = rptr_q ^ do_pop;
    count_d = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("queue count out of range");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || count_q == 2'd2) |-> (wptr_q == rptr_q))
    else $error("queue pointers disagree with count");

  a_pop_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0) |=> (count_q != 2'd2)) else $error("queue grew by two");

endmodule

/* hdl/gfp_back.sv */
// gfp_back: word assembly from commands and registered result stage
module gfp_back
  import gfp_pkg::*;
#(
  parameter int WordBits = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  gfp_cmd_t           cmd_i,
  output logic               cmd_pop_o,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output logic [PackedW-1:0] packed_word_o,
  output logic               last_word_o,
  output logic               bad_request_o
);

  localparam int UsedW = $clog2(WordBits + 1);
  localparam logic [UsedW-1:0] WordCnt  = UsedW'(WordBits);
  localparam logic [UsedW:0]   WordFull = (UsedW + 1)'(WordBits);

  logic [WordBits-1:0] word_q, word_d;
  logic [UsedW-1:0]    used_q, used_d;
  logic                res_valid_q, res_valid_d;
  logic [PackedW-1:0]  res_word_q;
  logic                res_last_q, res_bad_q;

  logic [UsedW-1:0]    wid, room, rest;
  logic [UsedW:0]      sum;
  logic                fits;
  logic [WordBits-1:0] coded_w, shifted, split_word;
  logic                emit, emit_last, emit_bad;
  logic [WordBits-1:0] emit_word;

  assign cmd_pop_o = cmd_valid_i && (!res_valid_q || res_ready_i);

  assign wid        = UsedW'(cmd_i.width);
  assign coded_w    = WordBits'(cmd_i.coded);
  assign sum        = {1'b0, used_q} + {1'b0, wid};
  assign fits       = (sum <= WordFull);
  assign room       = WordCnt - used_q;
  assign rest       = wid - room;
  assign shifted    = (word_q << wid) | coded_w;
  assign split_word = (word_q << room) | WordBits'(cmd_i.coded >> rest);

  always_comb begin
    word_d    = word_q;
    used_d    = used_q;
    emit      = 1'b0;
    emit_last = 1'b0;
    emit_bad  = 1'b0;
    emit_word = '0;
    case (cmd_i.kind)
      CmdFlush: begin
        word_d = '0;
        used_d = '0;
        if (used_q != '0) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          emit_word = word_q << (WordCnt - used_q);
        end
      end
      CmdBad: begin
        emit     = 1'b1;
        emit_bad = 1'b1;
      end
      CmdPack: begin
        if (fits) begin
          if (sum == WordFull) begin
            emit      = 1'b1;
            emit_word = shifted;
            word_d    = '0;
            used_d    = '0;
          end else begin
            word_d = shifted;
            used_d = sum[UsedW-1:0];
          end
        end else begin
          emit      = 1'b1;
          emit_word = split_word;
          word_d    = WordBits'(cmd_i.coded & ~({ValueW{1'b1}} << rest));
          used_d    = rest;
        end
      end
      default: begin
        emit     = 1'b1;
        emit_bad = 1'b1;
      end
    endcase
  end

  always_comb begin
    if (cmd_pop_o) begin
      res_valid_d = emit;
    end else begin
      res_valid_d = res_valid_q && !res_ready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q      <= '0;
      used_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (cmd_pop_o) begin
        word_q <= word_d;
        used_q <= used_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && emit) begin
      res_word_q <= PackedW'(emit_word);
      res_last_q <= emit_last;
      res_bad_q  <= emit_bad;
    end
  end

  assign res_valid_o   = res_valid_q;
  assign packed_word_o = res_word_q;
  assign last_word_o   = res_last_q;
  assign bad_request_o = res_bad_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q < WordCnt) else $error("fill count reached a full word");

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_pop_o && cmd_i.kind == CmdFlush) |=> (used_q == '0 && word_q == '0))
    else $error("flush left bits in the word");

  a_bad_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_pop_o && cmd_i.kind == CmdBad) |=> $stable(used_q))
    else $error("bad request changed the fill count");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_bad_q) |-> (res_word_q == '0 && !res_last_q))
    else $error("bad result carries data");

endmodule

/* hdl/gray_field_packer_core.sv */
// gray_field_packer_core: top level of the gray-coding variable-width bit packer
//
// Takes one request per clock cycle while the queue is not full: a field of
// MinField..MaxField bits is gray-coded and packed MSB first into WordBits-bit words,
// and a flush request pads and emits the partial word with last_word set. A request is
// checked and coded as it is accepted and enters a two-entry queue; the packing stage
// takes one queued command per cycle unless its result is held, and registers the
// result; the sustained rate is one request per cycle as long as results are taken.
// Bad requests give a result with bad_request set and a zero word, and leave the fill
// state as it was. The packed word on the port is the low 24 bits of the assembled word.
module gray_field_packer_core
  import gfp_pkg::*;
#(
  parameter int WordBits = 24,
  parameter int MinField = 2,
  parameter int MaxField = 20
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gfp_in_if.sink     req_i,
  gfp_out_if.source  res_o
);

  gfp_cmd_t front_cmd;
  gfp_cmd_t queue_cmd;
  logic     queue_full;
  logic     queue_valid;
  logic     queue_pop;

  assign req_i.ready = !queue_full;

  gfp_front #(
    .WordBits (WordBits),
    .MinField (MinField),
    .MaxField (MaxField)
  ) u_front (
    .req_type_i    (req_i.req_type),
    .field_width_i (req_i.field_width),
    .field_value_i (req_i.field_value),
    .cmd_o         (front_cmd)
  );

  gfp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (req_i.valid),
    .data_i  (front_cmd),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .valid_o (queue_valid),
    .data_o  (queue_cmd)
  );

  gfp_back #(
    .WordBits (WordBits)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (queue_valid),
    .cmd_i         (queue_cmd),
    .cmd_pop_o     (queue_pop),
    .res_valid_o   (res_o.valid),
    .res_ready_i   (res_o.ready),
    .packed_word_o (res_o.packed_word),
    .last_word_o   (res_o.last_word),
    .bad_request_o (res_o.bad_request)
  );

endmodule
